[src/cis_pkg.sv]
`default_nettype none

package cis_pkg;

	localparam int ID_W   = 16;
	localparam int POS_W  = 8;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD      = 2'd0,
		MODE_DELETE   = 2'd1,
		MODE_CONTAINS = 2'd2,
		MODE_READ_AT  = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_REJECT    = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Controls broadcast to every cell of the row
	typedef struct packed {
		logic add_en;
		logic del_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[src/cis_cell.sv]
`default_nettype none

module cis_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  wire logic                      clk,
	input  wire cis_pkg::cell_ctrl_t       ctrl,
	input  wire logic [cis_pkg::ID_W-1:0]  id,
	input  wire logic [CNT_W-1:0]          count,
	input  wire logic                      hit_in,
	input  wire logic [cis_pkg::ID_W-1:0]  next_entry,
	output logic                           hit_out,
	output logic [cis_pkg::ID_W-1:0]       entry
);
	import cis_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic [ID_W-1:0] entry_q;
	logic            occupied;
	logic            match;

	assign occupied = MY_IDX < count;
	assign match    = occupied && (entry_q == id);
	assign hit_out  = hit_in | match;
	assign entry    = entry_q;

	// Delete: every cell at or above the match takes its upper neighbour's entry.
	// Add: the first free cell takes the new id.
	always_ff @(posedge clk) begin
		if (ctrl.del_en && (hit_in || match)) begin
			entry_q <= next_entry;
		end else if (ctrl.add_en && (MY_IDX == count)) begin
			entry_q <= id;
		end
	end

endmodule

`default_nettype wire

[src/compacting_id_set.sv]
`default_nettype none

// Set of up to CAPACITY distinct 16-bit IDs, kept in insertion order in a row
// of cells. Pulse start with mode, id and position while busy is low; the
// request is taken at that edge. Exactly one result follows, registered
// through pend_q and then done_q: status, found, id_out and count are valid
// for the single cycle in which done is high, and the receiver cannot stall
// them, so capture them then. A request is first captured; then the compare,
// shift and update run across the cell row. busy is low again in the cycle
// that shows done, so a new start may be given there, but not earlier.
// reserved_id is written through cfg_we/cfg_wdata and must only change
// while no request is in flight. It resets to all ones.
module compacting_id_set #(
	parameter int CAPACITY = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [cis_pkg::MODE_W-1:0]            mode,
	input  wire logic signed [cis_pkg::ID_W-1:0]       id,
	input  wire logic [cis_pkg::POS_W-1:0]             position,
	input  wire logic                                  cfg_we,
	input  wire logic signed [cis_pkg::ID_W-1:0]       cfg_wdata,
	output logic                                       done,
	output logic [cis_pkg::STAT_W-1:0]                 status,
	output logic                                       found,
	output logic signed [cis_pkg::ID_W-1:0]            id_out,
	output logic [$clog2(CAPACITY+1)-1:0]              count
);
	import cis_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Captured request
	logic            pend_q;
	mode_t           mode_q;
	logic [ID_W-1:0] id_q;
	logic [POS_W-1:0] pos_q;

	logic [ID_W-1:0]  rsv_q;
	logic [CNT_W-1:0] count_q;

	// Registered result
	logic            done_q;
	status_t         status_q;
	logic            found_q;
	logic [ID_W-1:0] id_out_q;

	// Cell row: hit ripples upward, entries hand down on delete
	logic [CAPACITY:0]  hit;
	logic [ID_W-1:0]    cell_entry [CAPACITY];
	cell_ctrl_t         ctrl;

	logic            any_hit;
	logic            is_rsv;
	logic            full;
	logic            read_ok;
	logic [ID_W-1:0] rd_entry;
	status_t         status_d;
	logic            found_d;
	logic [ID_W-1:0] id_out_d;

	assign busy = pend_q;

	assign hit[0] = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [ID_W-1:0] up_entry;

		if (g == CAPACITY - 1) begin : g_top
			assign up_entry = '0;
		end else begin : g_mid
			assign up_entry = cell_entry[g+1];
		end

		cis_cell #(
			.INDEX (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.id         (id_q),
			.count      (count_q),
			.hit_in     (hit[g]),
			.next_entry (up_entry),
			.hit_out    (hit[g+1]),
			.entry      (cell_entry[g])
		);
	end

	assign any_hit  = hit[CAPACITY];
	assign is_rsv   = (id_q == rsv_q);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign read_ok  = (CMP_W'(pos_q) < CMP_W'(count_q));
	assign rd_entry = cell_entry[pos_q[IDX_W-1:0]];

	// Decide the outcome of the pending request from the row's hit chain
	always_comb begin
		ctrl     = '0;
		status_d = ST_OK;
		found_d  = 1'b0;
		id_out_d = '0;
		unique case (mode_q)
			MODE_ADD: begin
				if (is_rsv) begin
					status_d = ST_REJECT;
				end else if (any_hit) begin
					status_d = ST_OK;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.add_en = pend_q;
				end
			end
			MODE_DELETE: begin
				if (is_rsv) begin
					status_d = ST_REJECT;
				end else if (!any_hit) begin
					status_d = ST_NOT_FOUND;
				end else begin
					ctrl.del_en = pend_q;
				end
			end
			MODE_CONTAINS: begin
				found_d = any_hit;
			end
			MODE_READ_AT: begin
				if (read_ok) begin
					id_out_d = rd_entry;
				end else begin
					status_d = ST_REJECT;
					id_out_d = rsv_q;
				end
			end
		endcase
	end

	// Control: capture on transfer, resolve in the next cycle, strobe done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
			rsv_q   <= '1;
		end else begin
			done_q <= pend_q;
			if (pend_q) begin
				pend_q <= 1'b0;
				if (ctrl.add_en) begin
					count_q <= count_q + CNT_W'(1);
				end else if (ctrl.del_en) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (start) begin
				pend_q <= 1'b1;
			end
			if (cfg_we) begin
				rsv_q <= cfg_wdata;
			end
		end
	end

	// Payload: request fields and result fields, no reset needed
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q <= mode_t'(mode);
			id_q   <= id;
			pos_q  <= position;
		end
		if (pend_q) begin
			status_q <= status_d;
			found_q  <= found_d;
			id_out_q <= id_out_d;
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign found  = found_q;
	assign id_out = id_out_q;
	assign count  = count_q;

	// A captured request always resolves in the next cycle
	a_pend_done: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> done_q && !pend_q)
		else $error("pending request did not complete");

	// The count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count beyond capacity");

	// A failed request leaves the set size alone
	a_fail_keep: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q != ST_OK) |-> $stable(count_q))
		else $error("count changed on a failed request");

	// Only a lookup can report found, and then with status ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && found_q |-> (status_q == ST_OK) && (mode_q == MODE_CONTAINS))
		else $error("found raised outside a clean lookup");

endmodule

`default_nettype wire

[verif/tb.sv]
module tb;
	import cis_pkg::*;

	localparam int SLOTS    = 16;
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int POOL_N   = 20;
	localparam int PHASES   = 7;
	localparam int PHASE_N  = 250;

	// What the sender queue holds: a request, a write of the reserved ID,
	// or a pause until every outstanding result has come back.
	typedef enum logic [1:0] {
		ITEM_REQUEST,
		ITEM_WRITE,
		ITEM_DRAIN
	} item_kind_t;

	typedef struct {
		item_kind_t              kind;
		mode_t                   op;
		logic signed [ID_W-1:0]  key;
		logic [POS_W-1:0]        slot;
		logic signed [ID_W-1:0]  value;
	} pending_item_t;

	typedef struct {
		status_t                 status;
		logic                    found;
		logic signed [ID_W-1:0]  id_out;
		logic [CNT_W-1:0]        count;
	} outcome_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [MODE_W-1:0]       mode = '0;
	logic signed [ID_W-1:0]  id = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    cfg_we = 1'b0;
	logic signed [ID_W-1:0]  cfg_wdata = '0;
	logic                    busy;
	logic                    done;
	logic [STAT_W-1:0]       status;
	logic                    found;
	logic signed [ID_W-1:0]  id_out;
	logic [CNT_W-1:0]        count;

	pending_item_t pending[$];
	outcome_t      expected_results[$];
	int            errors = 0;

	// Sender bookkeeping, owned by the driver alone
	int in_flight = 0;
	int gap_left = 0;
	int burst_left = 0;

	// Shadow copy of the set, its size and the reserved ID
	logic signed [ID_W-1:0] stored_ids[SLOTS];
	int                     stored_n = 0;
	logic signed [ID_W-1:0] sentinel_id = '1;

	// IDs the random requests draw from; small enough that the set fills and empties
	logic signed [ID_W-1:0] key_pool[POOL_N];

	compacting_id_set #(
		.CAPACITY(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.id(id),
		.position(position),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.status(status),
		.found(found),
		.id_out(id_out),
		.count(count)
	);

	always #10 clk = ~clk;

	// Apply one request to the shadow set and return the result it should give.
	// Duplicates are looked for before the full test, so a duplicate add on a
	// full set still reports ok.
	function automatic outcome_t apply_request(mode_t op, logic signed [ID_W-1:0] key,
			logic [POS_W-1:0] slot);
		outcome_t r;
		int       hit;
		r = '{ST_OK, 1'b0, '0, '0};
		hit = -1;
		for (int i = 0; i < stored_n; i++) begin
			if (hit < 0 && stored_ids[i] == key)
				hit = i;
		end
		case (op)
			MODE_ADD: begin
				if (key == sentinel_id) begin
					r.status = ST_REJECT;
				end else if (hit < 0) begin
					if (stored_n >= SLOTS) begin
						r.status = ST_FULL;
					end else begin
						stored_ids[stored_n] = key;
						stored_n++;
					end
				end
			end
			MODE_DELETE: begin
				if (key == sentinel_id) begin
					r.status = ST_REJECT;
				end else if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					// close the gap: later entries move down one place
					for (int i = hit; i < stored_n - 1; i++)
						stored_ids[i] = stored_ids[i + 1];
					stored_n--;
				end
			end
			MODE_CONTAINS: begin
				r.found = (hit >= 0);
			end
			MODE_READ_AT: begin
				if (slot < stored_n) begin
					r.id_out = stored_ids[slot];
				end else begin
					r.status = ST_REJECT;
					r.id_out = sentinel_id;
				end
			end
		endcase
		r.count = CNT_W'(stored_n);
		return r;
	endfunction

	task automatic compare_field(string field, logic signed [31:0] want, logic signed [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	function automatic void queue_request(mode_t op, logic signed [ID_W-1:0] key,
			logic [POS_W-1:0] slot);
		pending.push_back('{ITEM_REQUEST, op, key, slot, '0});
	endfunction

	function automatic void queue_write(logic signed [ID_W-1:0] value);
		pending.push_back('{ITEM_WRITE, MODE_ADD, '0, '0, value});
	endfunction

	function automatic void queue_drain();
		pending.push_back('{ITEM_DRAIN, MODE_ADD, '0, '0, '0});
	endfunction

	// Random request: mostly pool IDs so adds, deletes and lookups hit, some
	// reserved IDs, a few wild ones; read_at mostly near the live range.
	function automatic void queue_random_request(logic signed [ID_W-1:0] reserved);
		int                     pick;
		mode_t                  op;
		logic signed [ID_W-1:0] key;
		logic [POS_W-1:0]       slot;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = MODE_ADD;
		else if (pick < 65)
			op = MODE_DELETE;
		else if (pick < 80)
			op = MODE_CONTAINS;
		else
			op = MODE_READ_AT;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			key = key_pool[$urandom_range(0, POOL_N - 1)];
		else if (pick < 95)
			key = reserved;
		else
			key = ID_W'($urandom);
		if ($urandom_range(0, 4) == 0)
			slot = POS_W'($urandom_range(0, 255));
		else
			slot = POS_W'($urandom_range(0, SLOTS + 1));
		queue_request(op, key, slot);
	endfunction

	// Driver: take items off the pending queue. Hold start high until the
	// transfer happens, idle in bursts, and only write the register or move
	// past a pause once nothing is outstanding.
	always @(posedge clk or negedge arst_n) begin : sender
		logic accepted;
		int   flight_now;
		logic next_start;
		logic next_we;
		int   next_gap;
		int   next_burst;
		if (!arst_n) begin
			start      <= 1'b0;
			mode       <= MODE_ADD;
			id         <= '0;
			position   <= '0;
			cfg_we     <= 1'b0;
			cfg_wdata  <= '0;
			in_flight  <= 0;
			gap_left   <= 0;
			burst_left <= 0;
		end else begin
			accepted   = start && !busy;
			flight_now = in_flight + int'(accepted) - int'(done);
			next_start = 1'b0;
			next_we    = 1'b0;
			next_gap   = gap_left;
			next_burst = burst_left;
			if (start && !accepted) begin
				// hold the request until the block takes it
				next_start = 1'b1;
			end else if (gap_left > 0) begin
				next_gap = gap_left - 1;
			end else if (pending.size() > 0) begin
				case (pending[0].kind)
					ITEM_WRITE: begin
						if (flight_now == 0) begin
							next_we = 1'b1;
							cfg_wdata <= pending[0].value;
							void'(pending.pop_front());
						end
					end
					ITEM_DRAIN: begin
						if (flight_now == 0)
							void'(pending.pop_front());
					end
					ITEM_REQUEST: begin
						next_start = 1'b1;
						mode     <= pending[0].op;
						id       <= pending[0].key;
						position <= pending[0].slot;
						void'(pending.pop_front());
						if (burst_left > 1) begin
							next_burst = burst_left - 1;
						end else if ($urandom_range(0, 9) < 2) begin
							// long stretch back to back
							next_burst = $urandom_range(30, 80);
							next_gap   = 0;
						end else begin
							next_burst = $urandom_range(1, 12);
							next_gap   = $urandom_range(0, 7);
						end
					end
				endcase
			end
			start      <= next_start;
			cfg_we     <= next_we;
			in_flight  <= flight_now;
			gap_left   <= next_gap;
			burst_left <= next_burst;
		end
	end

	// Monitor: track register writes, check each result against the oldest
	// prediction, then predict for a transfer taken at this edge. Checking
	// comes first so a fresh prediction never meets an older result.
	always @(posedge clk) begin : monitor
		outcome_t want;
		if (arst_n) begin
			if (cfg_we)
				sentinel_id = cfg_wdata;
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, status %0d found %0d id_out %0d count %0d",
						$time, status, found, id_out, count);
				end else begin
					want = expected_results.pop_front();
					compare_field("status", want.status, status);
					compare_field("found", want.found, found);
					compare_field("id_out", want.id_out, id_out);
					compare_field("count", want.count, count);
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_request(mode_t'(mode), id, position));
		end
	end

	initial begin : stimulus
		logic signed [ID_W-1:0] fill_keys[SLOTS];
		logic signed [ID_W-1:0] phase_reserved[PHASES];
		fill_keys = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFE, 16'h5555,
			16'hAAAA, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h1234, 16'h4321,
			16'h7FFE, 16'h8001, 16'h0100};
		phase_reserved = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, ID_W'($urandom),
			ID_W'($urandom), 16'hFFFF};

		// Empty set: out of range read, reserved ID on add, delete and lookup,
		// delete of something absent
		queue_request(MODE_READ_AT, 16'h0000, 8'd0);
		queue_request(MODE_ADD, 16'hFFFF, 8'd0);
		queue_request(MODE_DELETE, 16'hFFFF, 8'd0);
		queue_request(MODE_CONTAINS, 16'hFFFF, 8'd0);
		queue_request(MODE_DELETE, 16'h1234, 8'd0);
		// Fill to capacity, extremes first; then a new ID is full and a
		// duplicate is still ok
		foreach (fill_keys[i])
			queue_request(MODE_ADD, fill_keys[i], 8'd0);
		queue_request(MODE_ADD, 16'h2468, 8'd0);
		queue_request(MODE_ADD, 16'h7FFF, 8'd0);
		queue_request(MODE_CONTAINS, 16'h5555, 8'd0);
		// Drop the head entry so everything shifts down, then read the new head
		queue_request(MODE_DELETE, 16'h8000, 8'd0);
		queue_request(MODE_READ_AT, 16'h0000, 8'd0);
		queue_request(MODE_READ_AT, 16'h0000, 8'd255);

		// Random phases, each under its own reserved ID. The first pool entry
		// is the next phase's reserved ID, so the set may already hold it
		// when it becomes the sentinel.
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0)
				queue_write(phase_reserved[p]);
			for (int i = 0; i < POOL_N; i++) begin
				if (p == 0 || $urandom_range(0, 1) == 1)
					key_pool[i] = ID_W'($urandom);
			end
			if (p + 1 < PHASES)
				key_pool[0] = phase_reserved[p + 1];
			for (int n = 0; n < PHASE_N; n++) begin
				// mid-phase, let the pipe run dry before carrying on
				if (n == PHASE_N / 2)
					queue_drain();
				queue_random_request(phase_reserved[p]);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sample away from the clock edge so the queues are settled
		do
			@(negedge clk);
		while (pending.size() != 0 || start || expected_results.size() != 0);
		repeat (6) @(posedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
src/cis_pkg.sv
src/cis_cell.sv
src/compacting_id_set.sv
verif/tb.sv
